// ===== rtl/bres_pkg.sv =====
// ----------------------------------------------------------------------------
// bres_pkg: shared types and constants of the line rasterizer
// Field widths, command codes, tdata packing and controller/datapath structs.
// ----------------------------------------------------------------------------
package bres_pkg;

   // Coordinate width; all other coordinate-derived widths follow from it.
   localparam int COORD_BITS = 9;
   localparam int STRIDE_W   = 11;
   localparam int OFFS_W     = 19;
   localparam int COLOUR_W   = 16;
   localparam int ERR_W      = COORD_BITS + 3;
   localparam int PROD_W     = COORD_BITS + STRIDE_W;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(384);

   // Input tdata: start_x, start_y, end_x, end_y, line_colour
   localparam int REQ_FIELDS_W = 4 * COORD_BITS + COLOUR_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   // Output tdata: pixel_x, pixel_y, pixel_offset, pixel_colour
   localparam int RSP_FIELDS_W = 2 * COORD_BITS + OFFS_W + COLOUR_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Command codes carried on req_tuser
   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic load;   // latch endpoints and colour
      logic setup;  // derive axis, deltas and error from latched endpoints
      logic step;   // emit one pixel and advance the line
   } dp_cmd_type;

   typedef struct packed {
      logic line_active;
   } dp_status_type;

endpackage

// ===== rtl/bres_ctrl.sv =====
// ----------------------------------------------------------------------------
// bres_ctrl: controller of the line rasterizer
// Handles the request/response handshakes and sequences start and advance.
// ----------------------------------------------------------------------------
module bres_ctrl
   import bres_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          req_cmd,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    dp_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SETUP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // Take a new item only when the output register is free or drains now
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      dp_cmd       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_START: begin
                     dp_cmd.load = 1'b1;
                     state_in    = ST_SETUP;
                  end
                  CMD_ADVANCE: begin
                     // drop an advance while no line is active
                     if (status.line_active) begin
                        dp_cmd.step  = 1'b1;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            dp_cmd.setup = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/bres_dp.sv =====
// ----------------------------------------------------------------------------
// bres_dp: datapath of the line rasterizer
// Holds line state, stepping error term, stride register and pixel output.
// ----------------------------------------------------------------------------
module bres_dp
   import bres_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            dp_cmd,
   output dp_status_type         status,
   input  logic                  csr_write,
   input  logic [STRIDE_W-1:0]   csr_data,
   input  logic [REQ_DATA_W-1:0] req_data,
   output logic [RSP_DATA_W-1:0] rsp_data,
   output logic                  rsp_last
);

   // endpoints latched on start
   coord_type x0_ff, y0_ff, x1_ff, y1_ff;
   logic [COLOUR_W-1:0] colour_ff;

   // line state
   coord_type                 major_pos_ff, major_pos_in;
   coord_type                 minor_pos_ff, minor_pos_in;
   coord_type                 major_end_ff, major_end_in;
   coord_type                 major_delta_ff, major_delta_in;
   coord_type                 minor_delta_ff, minor_delta_in;
   logic signed [ERR_W-1:0]   error_ff, error_in;
   logic                      minor_down_ff, minor_down_in;
   logic                      steep_ff, steep_in;
   logic                      active_ff, active_in;
   logic [STRIDE_W-1:0]       stride_ff;

   // output register
   coord_type           out_x_ff, out_y_ff;
   logic [OFFS_W-1:0]   out_offs_ff;
   logic [COLOUR_W-1:0] out_colour_ff;
   logic                out_last_ff;

   // setup terms
   coord_type adx, ady, ma0, ma1, mi0, mi1, s_ma0, s_ma1, s_mi0, s_mi1;
   coord_type set_mad, set_mid;
   logic      set_steep, swap, set_down;

   // step terms
   coord_type               px, py;
   logic [PROD_W-1:0]       prod;
   logic [OFFS_W-1:0]       offs;
   logic                    last;
   logic                    err_pos;
   logic signed [ERR_W-1:0] two_mid, two_mad;

   assign status.line_active = active_ff;

   always_comb begin
      adx       = (x1_ff > x0_ff) ? x1_ff - x0_ff : x0_ff - x1_ff;
      ady       = (y1_ff > y0_ff) ? y1_ff - y0_ff : y0_ff - y1_ff;
      set_steep = !(ady < adx);
      ma0       = set_steep ? y0_ff : x0_ff;
      ma1       = set_steep ? y1_ff : x1_ff;
      mi0       = set_steep ? x0_ff : y0_ff;
      mi1       = set_steep ? x1_ff : y1_ff;
      // order endpoints so the major coordinate rises
      swap      = ma0 > ma1;
      s_ma0     = swap ? ma1 : ma0;
      s_ma1     = swap ? ma0 : ma1;
      s_mi0     = swap ? mi1 : mi0;
      s_mi1     = swap ? mi0 : mi1;
      set_mad   = s_ma1 - s_ma0;
      set_down  = s_mi1 < s_mi0;
      set_mid   = set_down ? s_mi0 - s_mi1 : s_mi1 - s_mi0;
   end

   always_comb begin
      px      = steep_ff ? minor_pos_ff : major_pos_ff;
      py      = steep_ff ? major_pos_ff : minor_pos_ff;
      prod    = PROD_W'(py) * PROD_W'(stride_ff);
      offs    = OFFS_W'(prod) + OFFS_W'(px);
      last    = (major_pos_ff == major_end_ff);
      err_pos = !error_ff[ERR_W-1] && (error_ff != '0);
      two_mid = signed'(ERR_W'({minor_delta_ff, 1'b0}));
      two_mad = signed'(ERR_W'({major_delta_ff, 1'b0}));
   end

   always_comb begin
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      major_end_in   = major_end_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      error_in       = error_ff;
      minor_down_in  = minor_down_ff;
      steep_in       = steep_ff;
      active_in      = active_ff;
      if (dp_cmd.setup) begin
         major_pos_in   = s_ma0;
         minor_pos_in   = s_mi0;
         major_end_in   = s_ma1;
         major_delta_in = set_mad;
         minor_delta_in = set_mid;
         minor_down_in  = set_down;
         steep_in       = set_steep;
         error_in       = signed'(ERR_W'({set_mid, 1'b0})) - signed'(ERR_W'(set_mad));
         active_in      = 1'b1;
      end else if (dp_cmd.step) begin
         if (last) begin
            active_in = 1'b0;
         end else begin
            if (err_pos) begin
               minor_pos_in = minor_down_ff ? minor_pos_ff - 1'b1 : minor_pos_ff + 1'b1;
               error_in     = error_ff + two_mid - two_mad;
            end else begin
               error_in     = error_ff + two_mid;
            end
            major_pos_in = major_pos_ff + 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         stride_ff <= STRIDE_RESET;
      end else begin
         active_ff <= active_in;
         if (csr_write) begin
            stride_ff <= csr_data;
         end
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         x0_ff     <= req_data[0 +: COORD_BITS];
         y0_ff     <= req_data[COORD_BITS +: COORD_BITS];
         x1_ff     <= req_data[2*COORD_BITS +: COORD_BITS];
         y1_ff     <= req_data[3*COORD_BITS +: COORD_BITS];
         colour_ff <= req_data[4*COORD_BITS +: COLOUR_W];
      end
      major_pos_ff   <= major_pos_in;
      minor_pos_ff   <= minor_pos_in;
      major_end_ff   <= major_end_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      error_ff       <= error_in;
      minor_down_ff  <= minor_down_in;
      steep_ff       <= steep_in;
      if (dp_cmd.step) begin
         out_x_ff      <= px;
         out_y_ff      <= py;
         out_offs_ff   <= offs;
         out_colour_ff <= colour_ff;
         out_last_ff   <= last;
      end
   end

   assign rsp_data = RSP_DATA_W'({out_colour_ff, out_offs_ff, out_y_ff, out_x_ff});
   assign rsp_last = out_last_ff;

endmodule

// ===== rtl/bresenham_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core: integer Bresenham line drawer
// Top level joining the handshake controller and the line datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries commands. req_tuser = 0 starts a line from the endpoints and
//   colour in req_tdata and gives no result; req_tuser = 1 advances one pixel.
//   An advance while no line is active is taken and dropped.
//   rsp_* returns one item per advance: coordinates, framebuffer offset
//   (pixel_y * row_stride + pixel_x, modulo 2^19) and colour, with tlast set
//   on the final pixel of the line, after which the engine goes idle.
//   csr_* writes row_stride and is always ready; write it only while the block
//   is idle. That is the user's duty; the block itself does not enforce it.
// Timing:
//   An accepted advance's pixel appears in the output register on the next
//   cycle, so one pixel per clock while rsp_tready holds. A start first
//   latches the endpoints, then runs the setup pass (axis choice, swap,
//   deltas, initial error) in ST_SETUP, during which req_tready is low.
//   The offset multiply and the error update are each combinational.
//   If the receiver stalls, the pixel waits in the output register and
//   req_tready stays low until it is taken.
//   Reset (synchronous): no line active, output empty, row_stride = 384.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_core
   import bres_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: start_x, start_y, end_x, end_y, line_colour (low bit up)
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // req_tuser: cmd
   input  logic                  req_tuser,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rsp_tdata: pixel_x, pixel_y, pixel_offset, pixel_colour (low bit up)
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tlast: last_pixel
   output logic                  rsp_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // row_stride write
   input  logic [STRIDE_W-1:0]   csr_data,
   input  logic                  csr_valid,
   output logic                  csr_ready
);

   dp_cmd_type    dp_cmd;
   dp_status_type status;

   // stride register accepts a write every cycle
   assign csr_ready = 1'b1;

   bres_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .dp_cmd     (dp_cmd)
   );

   bres_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .dp_cmd    (dp_cmd),
      .status    (status),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .req_data  (req_tdata),
      .rsp_data  (rsp_tdata),
      .rsp_last  (rsp_tlast)
   );

endmodule

// ===== bench/tb_bresenham_line_rasterizer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_rasterizer_core: line rasterizer stream check
// Drives start and advance commands, tracks the line state locally, and
// compares every returned pixel against the locally computed pixel. Runs
// short directed lines and then random line traffic under several row
// strides and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_bresenham_line_rasterizer_core;
   import bres_pkg::*;

   // Field positions inside rsp_tdata, lowest field first
   localparam int PX_LSB  = 0;
   localparam int PY_LSB  = COORD_BITS;
   localparam int OFF_LSB = 2 * COORD_BITS;
   localparam int COL_LSB = OFF_LSB + OFFS_W;

   typedef struct packed {
      logic                cmd;
      coord_type           x0;
      coord_type           y0;
      coord_type           x1;
      coord_type           y1;
      logic [COLOUR_W-1:0] colour;
   } line_cmd_type;

   typedef struct packed {
      coord_type           px;
      coord_type           py;
      logic [OFFS_W-1:0]   offset;
      logic [COLOUR_W-1:0] colour;
      logic                last;
   } pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = CMD_ADVANCE;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [STRIDE_W-1:0]   csr_data = '0;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;

   bresenham_line_rasterizer_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Local copy of the line engine state
   coord_type           ln_major     = '0;
   coord_type           ln_minor     = '0;
   coord_type           ln_major_end = '0;
   int                  ln_err        = 0;
   int                  ln_span_major = 0;
   int                  ln_span_minor = 0;
   bit                  ln_minor_dec  = 1'b0;
   bit                  ln_y_major    = 1'b0;
   bit                  ln_drawing    = 1'b0;
   logic [COLOUR_W-1:0] ln_colour     = '0;
   logic [STRIDE_W-1:0] ln_stride     = STRIDE_RESET;

   // Pixels still owed by the block, oldest first
   pixel_type pending_pixels[$];

   int send_gap_pct   = 0;   // chance in 100 per cycle that the sender holds off
   int stall_pct      = 0;   // chance in 100 per cycle that the receiver stalls
   int items_sent     = 0;   // starts and advances that do work
   int lines_started  = 0;
   int pixels_checked = 0;
   int stride_writes  = 0;
   int fail_count     = 0;

   // Rasterize one command: update the line state and return the pixel, if any
   function automatic bit rasterize_step(input line_cmd_type c, output pixel_type pix);
      int x0, y0, x1, y1, adx, ady, ma0, ma1, mi0, mi1, t;
      int unsigned lin;
      pix = '0;
      if (c.cmd == CMD_START) begin
         x0 = int'(c.x0);
         y0 = int'(c.y0);
         x1 = int'(c.x1);
         y1 = int'(c.y1);
         adx = (x1 > x0) ? x1 - x0 : x0 - x1;
         ady = (y1 > y0) ? y1 - y0 : y0 - y1;
         // Ties and single points take the steep path
         ln_y_major = !(ady < adx);
         if (ln_y_major) begin
            ma0 = y0; ma1 = y1; mi0 = x0; mi1 = x1;
         end else begin
            ma0 = x0; ma1 = x1; mi0 = y0; mi1 = y1;
         end
         // Order endpoints so the major coordinate rises
         if (ma0 > ma1) begin
            t = ma0; ma0 = ma1; ma1 = t;
            t = mi0; mi0 = mi1; mi1 = t;
         end
         ln_span_major = ma1 - ma0;
         ln_minor_dec  = (mi1 < mi0);
         ln_span_minor = ln_minor_dec ? mi0 - mi1 : mi1 - mi0;
         ln_major      = coord_type'(ma0);
         ln_major_end  = coord_type'(ma1);
         ln_minor      = coord_type'(mi0);
         ln_err        = 2 * ln_span_minor - ln_span_major;
         ln_colour     = c.colour;
         ln_drawing    = 1'b1;
         return 1'b0;
      end
      // Drop advances while no line is active
      if (!ln_drawing)
         return 1'b0;
      pix.px     = ln_y_major ? ln_minor : ln_major;
      pix.py     = ln_y_major ? ln_major : ln_minor;
      lin        = int'(pix.py) * int'(ln_stride) + int'(pix.px);
      pix.offset = lin[OFFS_W-1:0];
      pix.colour = ln_colour;
      pix.last   = (ln_major == ln_major_end);
      if (pix.last) begin
         ln_drawing = 1'b0;
      end else begin
         if (ln_err > 0) begin
            ln_minor = ln_minor_dec ? ln_minor - 1'b1 : ln_minor + 1'b1;
            ln_err   = ln_err + 2 * (ln_span_minor - ln_span_major);
         end else begin
            ln_err = ln_err + 2 * ln_span_minor;
         end
         ln_major = ln_major + 1'b1;
      end
      return 1'b1;
   endfunction

   // Receiver: stall at random per cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Check every accepted pixel against the oldest one owed
   always @(posedge clock) begin
      pixel_type want;
      pixel_type got;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got.px     = rsp_tdata[PX_LSB +: COORD_BITS];
         got.py     = rsp_tdata[PY_LSB +: COORD_BITS];
         got.offset = rsp_tdata[OFF_LSB +: OFFS_W];
         got.colour = rsp_tdata[COL_LSB +: COLOUR_W];
         got.last   = rsp_tlast;
         if (pending_pixels.size() == 0) begin
            $error("pixel out with none owed: x=%0d y=%0d", got.px, got.py);
            fail_count++;
         end else begin
            want = pending_pixels.pop_front();
            pixels_checked++;
            if (got.px !== want.px) begin
               $error("pixel_x: expected %0d, got %0d", want.px, got.px);
               fail_count++;
            end
            if (got.py !== want.py) begin
               $error("pixel_y: expected %0d, got %0d", want.py, got.py);
               fail_count++;
            end
            if (got.offset !== want.offset) begin
               $error("pixel_offset: expected %0d, got %0d", want.offset, got.offset);
               fail_count++;
            end
            if (got.colour !== want.colour) begin
               $error("pixel_colour: expected %h, got %h", want.colour, got.colour);
               fail_count++;
            end
            if (got.last !== want.last) begin
               $error("last_pixel: expected %0d, got %0d", want.last, got.last);
               fail_count++;
            end
         end
      end
   end

   // Send one item; predict its pixel once the block takes it
   task automatic send_item(input line_cmd_type c);
      pixel_type pix;
      // Hold off at random before presenting the item
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tuser  <= c.cmd;
      req_tdata  <= REQ_DATA_W'({c.colour, c.y1, c.x1, c.y0, c.x0});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (c.cmd == CMD_START || ln_drawing)
         items_sent++;
      if (c.cmd == CMD_START)
         lines_started++;
      if (rasterize_step(c, pix))
         pending_pixels.push_back(pix);
   endtask

   task automatic send_start(input int x0, input int y0, input int x1, input int y1,
                             input logic [COLOUR_W-1:0] colour);
      line_cmd_type c;
      c.cmd    = CMD_START;
      c.x0     = coord_type'(x0);
      c.y0     = coord_type'(y0);
      c.x1     = coord_type'(x1);
      c.y1     = coord_type'(y1);
      c.colour = colour;
      send_item(c);
   endtask

   task automatic send_advance();
      line_cmd_type c;
      // Fill the unused payload with noise; the block must ignore it
      c.cmd    = CMD_ADVANCE;
      c.x0     = coord_type'($urandom);
      c.y0     = coord_type'($urandom);
      c.x1     = coord_type'($urandom);
      c.y1     = coord_type'($urandom);
      c.colour = COLOUR_W'($urandom);
      send_item(c);
   endtask

   // Finish the open line, drain all pixels, then let the start pipeline settle
   task automatic wait_idle();
      while (ln_drawing)
         send_advance();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_row_stride(input logic [STRIDE_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      ln_stride = value;
      stride_writes++;
   endtask

   // Endpoint near a base coordinate, clamped on screen
   function automatic coord_type coord_near(input coord_type base);
      int t;
      t = int'(base) + int'($urandom_range(24)) - 12;
      if (t < 0)
         t = 0;
      if (t > 511)
         t = 511;
      return coord_type'(t);
   endfunction

   // Advances before any line: all taken, none answered
   task automatic test_idle_advance();
      repeat (2) send_advance();
   endtask

   // One line of each shape, drawn to the end
   task automatic test_line_shapes();
      send_start(0, 0, 0, 0, 16'h0000);     // single point
      repeat (2) send_advance();            // second one finds the engine idle
      send_start(3, 1, 0, 2, 16'hA5A5);     // shallow, swapped, minor falling
      repeat (4) send_advance();
      send_start(2, 0, 3, 5, 16'h1234);     // steep, minor rising
      repeat (6) send_advance();
      send_start(5, 5, 8, 8, 16'h00FF);     // diagonal: tie goes steep
      repeat (4) send_advance();
   endtask

   // Start while a line is active: the old line is dropped
   task automatic test_line_restart();
      send_start(511, 511, 0, 0, 16'hFFFF);
      repeat (2) send_advance();
      send_start(0, 511, 511, 0, 16'h8001);
      send_advance();
      send_start(511, 0, 500, 3, 16'h7FFE);
      repeat (2) send_advance();
      wait_idle();
   endtask

   // Random line traffic under one stride and one idling pattern
   task automatic test_random_traffic(input logic [STRIDE_W-1:0] stride, input int gap,
                                      input int stall, input int budget);
      int        target;
      int        n;
      int        r;
      bit        paused;
      coord_type x0, y0, x1, y1;
      write_row_stride(stride);
      send_gap_pct = gap;
      stall_pct    = stall;
      target       = items_sent + budget;
      paused       = 1'b0;
      while (items_sent < target) begin
         r = $urandom_range(99);
         if (r < 5) begin
            // Stray advance: answered only if a line is still open
            send_advance();
         end else begin
            x0 = coord_type'($urandom_range(511));
            y0 = coord_type'($urandom_range(511));
            if ($urandom_range(19) == 0) begin
               // Rare long line anywhere on screen
               x1 = coord_type'($urandom_range(511));
               y1 = coord_type'($urandom_range(511));
            end else begin
               x1 = coord_near(x0);
               y1 = coord_near(y0);
            end
            send_start(x0, y0, x1, y1, COLOUR_W'($urandom));
            n = ln_span_major + 1;
            // Cut some lines short so the next start replaces them
            if (r < 15)
               n = $urandom_range(n - 1);
            repeat (n) send_advance();
            if (r >= 90)
               send_advance();
         end
         // Hold the sender once until every pixel owed has come back
         if (!paused && items_sent >= target - budget / 2) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_pixels.size() != 0)
               @(posedge clock);
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part runs at the reset stride
      test_idle_advance();
      test_line_shapes();
      test_line_restart();

      test_random_traffic(STRIDE_W'(1024), 0, 0, 150);
      test_random_traffic(STRIDE_W'(0), 46, 0, 150);
      test_random_traffic(STRIDE_W'(2047), 0, 46, 150);
      test_random_traffic(STRIDE_W'(1), 18, 18, 150);
      test_random_traffic(STRIDE_W'($urandom_range(1024, 1)), 0, 0, 150);

      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d line starts and %0d checked pixels", lines_started,
               pixels_checked);
      $display("over %0d row stride settings (0, 1, 1024, 2047 among them)", stride_writes + 1);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
